// ===== hdl/record_checksum_engine_macros.svh =====
// Assertion macros for the record checksum engine.
// Included by the RTL files that carry concurrent checks; no other dependencies.
// Synthesis builds see empty bodies.
`ifndef RECORD_CHECKSUM_ENGINE_MACROS_SVH
`define RECORD_CHECKSUM_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset
`define RCE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define RCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RCE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/rce_pkg.sv =====
// Package for the record checksum engine: algorithm codes, CRC constants,
// per-byte CRC functions and the fold result type. No dependencies.
`timescale 1ns / 1ps

package rce_pkg;

  // Algorithm select codes
  typedef enum logic [1:0] {
    ALG_CRC8  = 2'd0,
    ALG_XOR   = 2'd1,
    ALG_SUM   = 2'd2,
    ALG_CRC32 = 2'd3
  } rce_alg_t;

  localparam logic [7:0]  CRC8_POLY   = 8'h8C;
  localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC32_START = 32'hFFFFFFFF;

  // Output of the fold logic for one byte
  typedef struct packed {
    logic [31:0] next_code;
    logic [31:0] checksum;
  } rce_fold_t;

  // Start value of the running code for an algorithm
  function automatic logic [31:0] start_value(rce_alg_t alg);
    return (alg == ALG_CRC32) ? CRC32_START : 32'd0;
  endfunction

  // Reflected CRC-8, one byte, eight bit steps unrolled
  function automatic logic [7:0] crc8_byte(logic [7:0] code, logic [7:0] data);
    logic [7:0] c;
    c = code ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC-32, one byte, eight bit steps unrolled
  function automatic logic [31:0] crc32_byte(logic [31:0] code, logic [7:0] data);
    logic [31:0] c;
    c = code ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/rce_in_if.sv =====
// Input channel of the record checksum engine: one record byte per item.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface rce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/rce_out_if.sv =====
// Result channel of the record checksum engine: one finished code per item.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface rce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

// ===== hdl/record_checksum_engine.sv =====
// Top level of the record checksum engine: input register, fold stage,
// result register. Depends on rce_pkg, rce_in_if, rce_out_if, rce_fold, record_checksum_engine_macros.svh.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload                        Handshake
//  data      in         data_byte[7:0], last_byte      valid/ready
//  result    out        checksum[31:0]                 valid/ready
//  cfg       in         cfg_wr_data[1:0] (algorithm)   cfg_wr_en, no wait
//
//  One byte is accepted per cycle while the input side is not held; a last
//  byte passes through the input register, then is folded into the result
//  register, where its result is offered.
//  Bytes not marked last always move through, so only a last byte waiting
//  on a full, stalled result register holds the input side.
//  rst (synchronous) selects CRC-8 and clears the running code and both
//  valid flags. A configuration write reloads the start value of the new algorithm.

module record_checksum_engine (
  input  logic        clk,
  input  logic        rst,
  rce_in_if.sink      data,
  rce_out_if.source   result,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);
  import rce_pkg::*;

  `include "record_checksum_engine_macros.svh"

  rce_alg_t    algorithm;
  logic [31:0] running_code;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_fire;

  logic        out_valid;
  logic [31:0] checksum;

  rce_fold_t   fold;

  // Input stage moves on unless a last byte meets a stalled result
  assign s1_fire    = s1_valid && (!s1_last || !out_valid || result.ready);
  assign data.ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data.ready) begin
      s1_valid <= data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data.ready && data.valid) begin
      s1_byte <= data.data_byte;
      s1_last <= data.last_byte;
    end
  end

  // Byte fold
  rce_fold u_fold (
    .algorithm    (algorithm),
    .running_code (running_code),
    .data_byte    (s1_byte),
    .fold         (fold)
  );

  // Algorithm register and running code
  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm    <= ALG_CRC8;
      running_code <= start_value(ALG_CRC8);
    end else if (cfg_wr_en) begin
      algorithm    <= rce_alg_t'(cfg_wr_data);
      running_code <= start_value(rce_alg_t'(cfg_wr_data));
    end else if (s1_fire) begin
      running_code <= s1_last ? start_value(algorithm) : fold.next_code;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      checksum <= fold.checksum;
    end
  end

  assign result.valid    = out_valid;
  assign result.checksum = checksum;

  // Checks
  `RCE_ASSERT_NEXT(a_reload_after_last, clk, rst,
    s1_fire && s1_last && !cfg_wr_en, running_code == start_value(algorithm),
    "running code not reloaded after last item")
  `RCE_ASSERT_NEXT(a_cfg_reload, clk, rst,
    cfg_wr_en, running_code == start_value(rce_alg_t'($past(cfg_wr_data))),
    "running code not reloaded on algorithm write")
  `RCE_ASSERT_NEXT(a_result_after_last, clk, rst,
    s1_fire && s1_last, out_valid,
    "last item did not produce a result")
  `RCE_ASSERT_NEXT(a_narrow_code, clk, rst,
    s1_fire && !cfg_wr_en && algorithm != ALG_CRC32, running_code[31:8] == 24'd0,
    "8-bit algorithm left upper code bits set")
  `RCE_ASSERT_IMP(a_stall_source, clk, rst,
    !data.ready, s1_valid && s1_last && out_valid && !result.ready,
    "input held without a blocked last item")

endmodule

// ===== hdl/rce_fold.sv =====
// Fold logic: folds one byte into the running code for the selected
// algorithm and forms the finished code. Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_fold (
  input  rce_pkg::rce_alg_t algorithm,
  input  logic [31:0]       running_code,
  input  logic [7:0]        data_byte,
  output rce_pkg::rce_fold_t fold
);
  import rce_pkg::*;

  logic [31:0] next_code;

  // Per-algorithm update; 8-bit algorithms keep the upper bits clear
  always_comb begin
    case (algorithm)
      ALG_CRC8: begin
        next_code = {24'd0, crc8_byte(running_code[7:0], data_byte)};
      end
      ALG_XOR: begin
        next_code = {24'd0, running_code[7:0] ^ data_byte};
      end
      ALG_SUM: begin
        next_code = {24'd0, running_code[7:0] + data_byte};
      end
      ALG_CRC32: begin
        next_code = crc32_byte(running_code, data_byte);
      end
      default: begin
        next_code = 32'd0;
      end
    endcase
  end

  // Finished code: CRC-32 inverted, the others zero-extended
  always_comb begin
    fold.next_code = next_code;
    fold.checksum  = (algorithm == ALG_CRC32) ? ~next_code : {24'd0, next_code[7:0]};
  end

endmodule
